// ===== rtl/max_heap_priority_queue_unit_defines.svh =====
// Assertion macros for the priority queue RTL.
// Depends on clk and rst_n being visible in the including module.
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MHPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MHPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mhpq_pkg.sv =====
// Shared constants, codes and types for the priority queue.
// No dependencies.
package mhpq_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 7;
  localparam int CAP_RESET = 64;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // register index of capacity_limit
  localparam logic REG_CAPACITY = 1'b0;

  // broadcast to every cell
  typedef struct packed {
    logic             ins;  // insert key, shift lower part down
    logic             ext;  // drop head, shift everything up
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

// ===== rtl/max_heap_priority_queue_unit.sv =====
// Max priority queue: top level with the cell chain, count, config and output register.
// Depends on mhpq_pkg, mhpq_cell and max_heap_priority_queue_unit_defines.svh.
//
// Usage:
//  - Input channel (in_valid/in_stall): one transfer carries an operation
//    (insert, extract max, peek max) and a key used only by insert.
//  - Output channel (out_valid/out_stall): exactly one transfer per input
//    transfer, in order: key_out, status (ok/empty/full), entry_count.
//  - Timing: the result is registered and shows on the output in the cycle
//    after the input transfer.
//  - Throughput: one item per cycle when not stalled. Each operation is a single
//    parallel step of the cell chain: every cell compares its key with the
//    incoming key and either holds, loads the new key or takes a neighbor's key.
//  - in_stall rises only while a result sits unaccepted in the output
//    register and out_stall is high; a result leaving frees room in the
//    same cycle for the next item.
//  - Reset (rst_n low, synchronous) empties the queue, drops any pending
//    result and sets capacity_limit to 64. Cell contents are not cleared:
//    only cells below the count are ever used.
//  - capacity_limit is written over the APB-style port at address 0;
//    values above 64 act as 64. Write only while the block is idle.
`include "max_heap_priority_queue_unit_defines.svh"

module max_heap_priority_queue_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [mhpq_pkg::KEY_W-1:0]  in_key_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mhpq_pkg::KEY_W-1:0]  out_key_out,
  output logic [1:0]                  out_status,
  output logic [mhpq_pkg::CNT_W-1:0]  out_entry_count,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mhpq_pkg::ADDR_W-1:0] paddr,
  input  logic [mhpq_pkg::DATA_W-1:0] pwdata,
  output logic [mhpq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int DEPTH = mhpq_pkg::DEPTH;
  localparam int KEY_W = mhpq_pkg::KEY_W;
  localparam int CNT_W = mhpq_pkg::CNT_W;
  localparam int CAP_W = mhpq_pkg::CAP_W;

  // ---------------- configuration ----------------
  logic [CAP_W-1:0] cap_val_r;
  logic             cfg_wr;
  logic             cfg_sel_cap;

  assign pready      = 1'b1;
  assign cfg_sel_cap = (paddr[2] == mhpq_pkg::REG_CAPACITY);
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_val_r <= CAP_W'(mhpq_pkg::CAP_RESET);
    end else if (cfg_wr && cfg_sel_cap) begin
      cap_val_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_sel_cap) begin
      prdata = {{(mhpq_pkg::DATA_W-CAP_W){1'b0}}, cap_val_r};
    end
  end

  // ---------------- handshake ----------------
  logic out_valid_r;
  logic out_valid_nxt;
  logic in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // ---------------- count and decode ----------------
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             full;
  logic             empty;

  logic [KEY_W-1:0] res_key;
  logic [1:0]       res_status;

  mhpq_pkg::cell_ctl_t ctl;

  logic [KEY_W-1:0] cell_key [DEPTH];
  logic             cell_ge  [DEPTH];

  assign eff_cap = (CNT_W'(cap_val_r) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_val_r);
  assign full    = (count_r >= eff_cap);
  assign empty   = (count_r == '0);

  always_comb begin
    ctl.ins    = 1'b0;
    ctl.ext    = 1'b0;
    ctl.key    = in_key_in;
    count_nxt  = count_r;
    res_key    = '0;
    res_status = mhpq_pkg::ST_OK;
    case (in_operation)
      mhpq_pkg::OP_INSERT: begin
        if (full) begin
          res_status = mhpq_pkg::ST_FULL;
        end else begin
          ctl.ins   = in_accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      mhpq_pkg::OP_EXTRACT: begin
        if (empty) begin
          res_status = mhpq_pkg::ST_EMPTY;
        end else begin
          res_key   = cell_key[0];
          ctl.ext   = in_accept;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      mhpq_pkg::OP_PEEK: begin
        if (empty) begin
          res_status = mhpq_pkg::ST_EMPTY;
        end else begin
          res_key = cell_key[0];
        end
      end
      default: begin
        // unused code: no change, ok status
        res_status = mhpq_pkg::ST_OK;
      end
    endcase
  end

  // ---------------- cell chain ----------------
  // Cell 0 always holds the maximum. prev_ge of cell 0 is tied high so a
  // new largest key lands there; the last cell refills from itself.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             occ;
    logic             p_ge;
    logic [KEY_W-1:0] p_key;
    logic [KEY_W-1:0] n_key;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign p_ge  = 1'b1;
      assign p_key = in_key_in;
    end else begin : g_body
      assign p_ge  = cell_ge[i-1];
      assign p_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_key = cell_key[i];
    end else begin : g_mid
      assign n_key = cell_key[i+1];
    end

    mhpq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (occ),
      .prev_ge  (p_ge),
      .prev_key (p_key),
      .next_key (n_key),
      .key_q    (cell_key[i]),
      .ge       (cell_ge[i])
    );
  end

  // ---------------- state and output register ----------------
  logic [KEY_W-1:0] out_key_r;
  logic [1:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_key_r    <= res_key;
      out_status_r <= res_status;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_out     = out_key_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  // ---------------- assertions ----------------
  `MHPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `MHPQ_ASSERT_IMP(a_head_sorted, count_r >= CNT_W'(2), cell_key[0] >= cell_key[1],
                   "chain head not sorted")
  `MHPQ_ASSERT_NXT(a_insert_count,
                   in_accept && (in_operation == mhpq_pkg::OP_INSERT) && !full,
                   count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `MHPQ_ASSERT_NXT(a_extract_key,
                   in_accept && (in_operation == mhpq_pkg::OP_EXTRACT) && !empty,
                   out_key_out == $past(cell_key[0]), "extract returned wrong key")

endmodule

// ===== rtl/mhpq_cell.sv =====
// One slot of the sorted key chain; keys descend from cell 0 onward.
// Depends on mhpq_pkg.
module mhpq_cell (
  input  logic                      clk,
  input  mhpq_pkg::cell_ctl_t       ctl,
  input  logic                      occupied,
  input  logic                      prev_ge,
  input  logic [mhpq_pkg::KEY_W-1:0] prev_key,
  input  logic [mhpq_pkg::KEY_W-1:0] next_key,
  output logic [mhpq_pkg::KEY_W-1:0] key_q,
  output logic                      ge
);

  logic [mhpq_pkg::KEY_W-1:0] key_r;
  logic [mhpq_pkg::KEY_W-1:0] key_nxt;

  // held key stays ahead of the new one (ties keep older in front)
  assign ge = occupied && (key_r >= ctl.key);

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (ge) begin
        key_nxt = key_r;
      end else if (prev_ge) begin
        key_nxt = ctl.key;
      end else begin
        key_nxt = prev_key;
      end
    end else if (ctl.ext) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for max_heap_priority_queue_unit: directed table plus random traffic.
// Depends on mhpq_pkg and the max_heap_priority_queue_unit RTL; expected results come from a
// behavioral heap kept alongside the DUT, or from the table for hand-entered directed rows.
module testbench;

  localparam int KEY_W  = mhpq_pkg::KEY_W;
  localparam int CNT_W  = mhpq_pkg::CNT_W;
  localparam int CAP_W  = mhpq_pkg::CAP_W;
  localparam int ADDR_W = mhpq_pkg::ADDR_W;
  localparam int DATA_W = mhpq_pkg::DATA_W;
  localparam int DEPTH  = mhpq_pkg::DEPTH;

  // opcode the block must treat as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } answer_t;

  // one directed item; when wr_cap is set the capacity is rewritten before the item
  typedef struct packed {
    logic             wr_cap;
    logic [CAP_W-1:0] cap_val;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic             typed;   // use the hand-entered answer below
    logic [KEY_W-1:0] exp_key;
    logic [1:0]       exp_status;
    logic [CNT_W-1:0] exp_count;
  } dir_row_t;

  localparam int DIR_N = 25;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_operation = mhpq_pkg::OP_PEEK;
  logic [KEY_W-1:0]  in_key_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [KEY_W-1:0]  out_key_out;
  logic [1:0]        out_status;
  logic [CNT_W-1:0]  out_entry_count;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // behavioral heap image, fill level and capacity copy
  logic [KEY_W-1:0] heap_img [DEPTH];
  int               heap_fill = 0;
  logic [CAP_W-1:0] cap_shadow = CAP_W'(mhpq_pkg::CAP_RESET);

  answer_t  answer_q [$];
  dir_row_t dir_tab [DIR_N];
  int       fail_cnt = 0;
  int       idle_pct = 0;   // sender gap odds, percent per cycle
  int       stall_pct = 0;  // receiver stall odds, percent per cycle

  max_heap_priority_queue_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key_in       (in_key_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key_out     (out_key_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Applies one operation to the heap image and returns the answer the block owes.
  function automatic answer_t heap_apply(logic [1:0] op, logic [KEY_W-1:0] key);
    answer_t          ans;
    int               lim;
    int               pos;
    int               up;
    int               big;
    logic [KEY_W-1:0] tmp;
    ans = '{key: '0, status: mhpq_pkg::ST_OK, count: '0};
    lim = (int'(cap_shadow) < DEPTH) ? int'(cap_shadow) : DEPTH;
    if (op == mhpq_pkg::OP_INSERT) begin
      if (heap_fill >= lim) begin
        ans.status = mhpq_pkg::ST_FULL;
      end else begin
        heap_img[heap_fill] = key;
        pos = heap_fill;
        heap_fill++;
        // sift up while strictly above the parent
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_img[pos] <= heap_img[up]) break;
          tmp = heap_img[pos];
          heap_img[pos] = heap_img[up];
          heap_img[up] = tmp;
          pos = up;
        end
      end
    end else if (op == mhpq_pkg::OP_EXTRACT || op == mhpq_pkg::OP_PEEK) begin
      if (heap_fill == 0) begin
        ans.status = mhpq_pkg::ST_EMPTY;
      end else begin
        ans.key = heap_img[0];
        if (op == mhpq_pkg::OP_EXTRACT) begin
          heap_fill--;
          heap_img[0] = heap_img[heap_fill];
          // sift down toward the larger child, left wins a tie
          pos = 0;
          while (2 * pos + 1 < heap_fill) begin
            big = 2 * pos + 1;
            if (big + 1 < heap_fill && heap_img[big + 1] > heap_img[big]) big = big + 1;
            if (heap_img[pos] >= heap_img[big]) break;
            tmp = heap_img[pos];
            heap_img[pos] = heap_img[big];
            heap_img[big] = tmp;
            pos = big;
          end
        end
      end
    end
    ans.count = CNT_W'(heap_fill);
    return ans;
  endfunction

  // Drives one item, holds it until the transfer, then books its answer.
  task automatic issue_op(logic [1:0] op, logic [KEY_W-1:0] key, logic typed, answer_t typed_ans);
    answer_t ans;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key_in    <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ans = heap_apply(op, key);
    answer_q.push_back(typed ? typed_ans : ans);
  endtask

  // Input idle and every booked answer returned; a few spare cycles for the output register.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write of capacity_limit followed by a read back.
  task automatic write_capacity(logic [CAP_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * mhpq_pkg::REG_CAPACITY);
    pwdata  <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_shadow = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(val)) begin
      $error("capacity_limit mismatch: expected %0d, got %0d", val, prdata);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic under one capacity and one idling mix. Ops lean toward
  // inserts while filling and toward extracts while draining, so the heap
  // swings between empty and full with random keys.
  task automatic run_phase(int gap, int stall, logic [CAP_W-1:0] cap, int n_items);
    int               r;
    int               lim;
    bit               filling;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    wait_drained();
    idle_pct  = gap;
    stall_pct = stall;
    write_capacity(cap);
    filling = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      lim = (int'(cap_shadow) < DEPTH) ? int'(cap_shadow) : DEPTH;
      if (heap_fill >= lim) filling = 1'b0;
      else if (heap_fill == 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < (filling ? 65 : 20)) op = mhpq_pkg::OP_INSERT;
      else if (r < 82) op = mhpq_pkg::OP_EXTRACT;
      else if (r < 97) op = mhpq_pkg::OP_PEEK;
      else op = OP_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 12) key = KEY_W'($urandom_range(0, 7));   // small keys force ties
      else if (r < 15) key = '0;
      else if (r < 18) key = '1;
      else key = $urandom;
      issue_op(op, key, 1'b0, '0);
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result checker: every transfer out must match the oldest booked answer
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result transfer: key_out %h status %0d entry_count %0d",
               out_key_out, out_status, out_entry_count);
        fail_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (out_key_out !== want.key) begin
          $error("key_out mismatch: expected %h, got %h", want.key, out_key_out);
          fail_cnt++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count mismatch: expected %0d, got %0d", want.count, out_entry_count);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    // wr_cap, cap, op, key, typed, exp key, exp status, exp count
    dir_tab = '{
      '{1'b0, 7'd0, mhpq_pkg::OP_PEEK, 32'h0, 1'b1, 32'h0, mhpq_pkg::ST_EMPTY, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h1234_5678, 1'b1, 32'h0, mhpq_pkg::ST_EMPTY, 7'd0},
      '{1'b0, 7'd0, OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd1},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'h0, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd2},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'h0000_0005, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'h8000_0000, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_PEEK, 32'h0, 1'b1, 32'hFFFF_FFFF, mhpq_pkg::ST_OK, 7'd5},
      '{1'b0, 7'd0, OP_UNUSED, 32'h0, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd5},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b1, 32'hFFFF_FFFF, mhpq_pkg::ST_OK, 7'd4},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'hFFFF_FFFF, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd0},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b1, 32'h0, mhpq_pkg::ST_EMPTY, 7'd0},
      // zero capacity refuses everything
      '{1'b1, 7'd0, mhpq_pkg::OP_INSERT, 32'h0000_0007, 1'b1, 32'h0, mhpq_pkg::ST_FULL, 7'd0},
      // capacity above the store acts as the store depth
      '{1'b1, 7'd127, mhpq_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd1},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'h5555_5555, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd2},
      // capacity dropped under the count: inserts refused, extracts still work
      '{1'b1, 7'd1, mhpq_pkg::OP_INSERT, 32'h0000_0009, 1'b1, 32'h0, mhpq_pkg::ST_FULL, 7'd2},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b1, 32'hAAAA_AAAA, mhpq_pkg::ST_OK, 7'd1},
      '{1'b0, 7'd0, mhpq_pkg::OP_INSERT, 32'h0000_0009, 1'b1, 32'h0, mhpq_pkg::ST_FULL, 7'd1},
      '{1'b0, 7'd0, mhpq_pkg::OP_EXTRACT, 32'h0, 1'b1, 32'h5555_5555, mhpq_pkg::ST_OK, 7'd0},
      '{1'b1, 7'd64, mhpq_pkg::OP_INSERT, 32'h0000_0001, 1'b1, 32'h0, mhpq_pkg::ST_OK, 7'd1},
      '{1'b1, 7'd2, mhpq_pkg::OP_INSERT, 32'h0000_0002, 1'b0, 32'h0, mhpq_pkg::ST_OK, 7'd0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cap) begin
        wait_drained();
        write_capacity(dir_tab[i].cap_val);
      end
      issue_op(dir_tab[i].op, dir_tab[i].key, dir_tab[i].typed,
               '{key: dir_tab[i].exp_key, status: dir_tab[i].exp_status,
                 count: dir_tab[i].exp_count});
    end

    // sender gap %, receiver stall %, capacity, items
    run_phase(0,  0,  7'd64,  320);
    run_phase(84, 0,  7'd127, 250);
    run_phase(0,  84, CAP_W'($urandom_range(2, 63)), 250);
    run_phase(24, 24, 7'd64,  250);
    run_phase(0,  0,  7'd1,   60);
    run_phase(24, 24, 7'd0,   40);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("max_heap_priority_queue_unit verification clean");
    end else begin
      $display("max_heap_priority_queue_unit verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(5_000_000);
    $display("max_heap_priority_queue_unit verification failed");
    $finish;
  end

endmodule
